// ===== rtl/bsmm_pkg.sv =====
// Shared types and constants of the bank switching memory mapper.
package bsmm_pkg;

  // Bus access kinds carried on the input tuser field.
  localparam logic [1:0] FUNC_CPU_READ  = 2'd0;
  localparam logic [1:0] FUNC_CPU_WRITE = 2'd1;
  localparam logic [1:0] FUNC_PPU_READ  = 2'd2;

  // Translation targets.
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_ROM = 2'd1;
  localparam logic [1:0] TGT_PRG_RAM = 2'd2;
  localparam logic [1:0] TGT_CHR_ROM = 2'd3;

  // Low register window: decode mask and addresses.
  localparam logic [15:0] LOW_REG_MASK = 16'hF803;
  localparam logic [15:0] REG_ZERO     = 16'h5000;
  localparam logic [15:0] REG_MUL_LO   = 16'h5800;
  localparam logic [15:0] REG_MUL_HI   = 16'h5801;
  localparam logic [15:0] REG_SCRATCH  = 16'h5803;

  // High register window: decode mask and addresses.
  localparam logic [15:0] HIGH_REG_MASK = 16'hF007;
  localparam logic [15:0] SEL4_MASK     = 16'hFFFC;
  localparam logic [15:0] SEL8_MASK     = 16'hFFF8;
  localparam logic [15:0] REG_PRG_BASE  = 16'h8000;
  localparam logic [15:0] REG_CHR_LO    = 16'h9000;
  localparam logic [15:0] REG_CHR_HI    = 16'hA000;
  localparam logic [15:0] REG_MODE      = 16'hD000;
  localparam logic [15:0] REG_MIRROR    = 16'hD001;
  localparam logic [15:0] REG_CHR_CTRL  = 16'hD003;

  // Fixed PRG banks, pre-shifted per mode (0x3C, 0x3E and 0x3F).
  localparam logic [6:0] PRG_FIX_32K = 7'h0F;
  localparam logic [6:0] PRG_FIX_16K = 7'h1F;
  localparam logic [6:0] PRG_FIX_8K  = 7'h3F;

  // CHR modes.
  localparam logic [1:0] CHR_MODE_8K = 2'd0;
  localparam logic [1:0] CHR_MODE_4K = 2'd1;
  localparam logic [1:0] CHR_MODE_2K = 2'd2;
  localparam logic [1:0] CHR_MODE_1K = 2'd3;

  localparam int BANK_W = 19;

  // Control captured with a PPU request for the CHR bank stage.
  typedef struct packed {
    logic [1:0] mode;
    logic       block_en;
    logic [2:0] block_num;
    logic       low_valid;
    logic       high_valid;
    logic [2:0] k;
  } chr_ctrl_t;

endpackage

// ===== rtl/bsmm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bsmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bsmm_chr_bank.sv =====
// CHR bank composition from the CHR register read data and captured mode bits.
module bsmm_chr_bank (
  input  bsmm_pkg::chr_ctrl_t          ctrl,
  input  logic [7:0]                   low_data,
  input  logic [7:0]                   high_data,
  output logic [bsmm_pkg::BANK_W-1:0]  bank
);

  logic [7:0]  low;
  logic [7:0]  high;
  logic [15:0] value;

  // Entries never written since reset read as zero.
  assign low  = ctrl.low_valid  ? low_data  : 8'd0;
  assign high = ctrl.high_valid ? high_data : 8'd0;

  // Register value: block mode replaces the upper bits with the block number.
  always_comb begin
    if (ctrl.block_en) begin
      case (ctrl.mode)
        bsmm_pkg::CHR_MODE_8K: value = {8'd0, ctrl.block_num, low[4:0]};
        bsmm_pkg::CHR_MODE_4K: value = {7'd0, ctrl.block_num, low[5:0]};
        bsmm_pkg::CHR_MODE_2K: value = {6'd0, ctrl.block_num, low[6:0]};
        default:               value = {5'd0, ctrl.block_num, low};
      endcase
    end else begin
      value = {high, low};
    end
  end

  // Scale to 1KB units and add the slot within the window.
  always_comb begin
    case (ctrl.mode)
      bsmm_pkg::CHR_MODE_8K: bank = {value, ctrl.k};
      bsmm_pkg::CHR_MODE_4K: bank = {1'b0, value, ctrl.k[1:0]};
      bsmm_pkg::CHR_MODE_2K: bank = {2'b0, value, ctrl.k[0]};
      default:               bank = {3'b0, value};
    endcase
  end

endmodule

// ===== rtl/bank_switching_memory_mapper_unit.sv =====
// Top level of the bank switching memory mapper.
//
// One bus access enters per request on the in_ stream: tuser carries the
// access kind (CPU read, CPU write or PPU read), tdata the address and the
// write byte. Each access gives exactly one result on the out_ stream: the
// mapper's own read byte and hit flag, the target kind, the bank, the offset,
// the PRG RAM write strobe and the current mirroring mode.
// Register writes take effect at acceptance, so the next access already sees
// them. The CHR bank registers live in two 8-entry RAMs read when the access
// is accepted; the bank is finished in the following cycle from that data.
// A result passes the RAM stage and then the output register. Throughput is one
// access per cycle while out_tready is high, set by one RAM read per access.
// Reset (rst_n low, synchronous) clears all mapper registers and the RAM
// valid bits, so never-written CHR registers read as zero; no clearing pass.
// When the receiver stalls, the result and the RAM stage hold, and one more
// access can still be taken into the RAM stage before in_tready falls.
module bank_switching_memory_mapper_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], data_in[23:16]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_data[7:0], bank[26:8], offset[39:27],
                                  // ram_write[40], mirroring[42:41], zero fill
  output logic [2:0]  out_tuser   // register_hit[0], target[2:1]
);

  localparam int BW = bsmm_pkg::BANK_W;

  // Input fields.
  logic [1:0]  func;
  logic [15:0] addr;
  logic [7:0]  din;
  assign func = in_tuser;
  assign addr = in_tdata[15:0];
  assign din  = in_tdata[23:16];

  // Mapper state.
  logic [6:0] prg_regs_r [4];
  logic [2:0] prg_mode_r;
  logic [1:0] chr_mode_r;
  logic       ram_en_r;
  logic       chr_mirror_r;
  logic       blk_en_r;
  logic [2:0] blk_num_r;
  logic [1:0] mirror_r;
  logic [7:0] mul0_r;
  logic [7:0] mul1_r;
  logic [7:0] scratch_r;
  logic [7:0] chr_lo_vld_r;
  logic [7:0] chr_hi_vld_r;

  // Pipeline control.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic accept;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  // Access decode.
  logic        is_rd;
  logic        is_wr;
  logic        is_ppu;
  logic [15:0] low_sel;
  logic [15:0] high_sel;
  logic        ram_win;
  assign is_rd    = (func == bsmm_pkg::FUNC_CPU_READ);
  assign is_wr    = (func == bsmm_pkg::FUNC_CPU_WRITE);
  assign is_ppu   = (func == bsmm_pkg::FUNC_PPU_READ);
  assign low_sel  = addr & bsmm_pkg::LOW_REG_MASK;
  assign high_sel = addr & bsmm_pkg::HIGH_REG_MASK;
  assign ram_win  = (addr[15:13] == 3'b011) && ram_en_r;

  // Register write strobes.
  logic wr_mul0, wr_mul1, wr_scratch, wr_prg, wr_chr_lo, wr_chr_hi;
  logic wr_mode, wr_mirror, wr_chr_ctrl;
  always_comb begin
    wr_mul0     = accept && is_wr && (low_sel == bsmm_pkg::REG_MUL_LO);
    wr_mul1     = accept && is_wr && (low_sel == bsmm_pkg::REG_MUL_HI);
    wr_scratch  = accept && is_wr && (low_sel == bsmm_pkg::REG_SCRATCH);
    wr_prg      = accept && is_wr &&
                  ((high_sel & bsmm_pkg::SEL4_MASK) == bsmm_pkg::REG_PRG_BASE);
    wr_chr_lo   = accept && is_wr &&
                  ((high_sel & bsmm_pkg::SEL8_MASK) == bsmm_pkg::REG_CHR_LO);
    wr_chr_hi   = accept && is_wr &&
                  ((high_sel & bsmm_pkg::SEL8_MASK) == bsmm_pkg::REG_CHR_HI);
    wr_mode     = accept && is_wr && (high_sel == bsmm_pkg::REG_MODE);
    wr_mirror   = accept && is_wr && (high_sel == bsmm_pkg::REG_MIRROR);
    wr_chr_ctrl = accept && is_wr && (high_sel == bsmm_pkg::REG_CHR_CTRL);
  end

  // Multiplier product for the register read window.
  logic [15:0] prod;
  assign prod = mul0_r * mul1_r;

  // PRG bank selection in 8KB units.
  logic [1:0] slot;
  logic       use3;
  logic [8:0] prg_bank;
  assign slot = addr[14:13];
  assign use3 = prg_mode_r[2];
  always_comb begin
    case (prg_mode_r[1:0])
      2'd0: prg_bank = {(use3 ? prg_regs_r[3] : bsmm_pkg::PRG_FIX_32K), slot};
      2'd1: begin
        if (!slot[1]) begin
          prg_bank = {1'b0, prg_regs_r[1], slot[0]};
        end else begin
          prg_bank = {1'b0, (use3 ? prg_regs_r[3] : bsmm_pkg::PRG_FIX_16K), slot[0]};
        end
      end
      default: begin
        if (slot != 2'd3) begin
          prg_bank = {2'b0, prg_regs_r[slot]};
        end else begin
          prg_bank = {2'b0, (use3 ? prg_regs_r[3] : bsmm_pkg::PRG_FIX_8K)};
        end
      end
    endcase
  end

  // CHR register index for a PPU read, with the mirroring fold of the 2KB and 1KB modes.
  logic [2:0] chr_k;
  logic [2:0] chr_base;
  logic [2:0] chr_idx;
  assign chr_k = addr[12:10];
  always_comb begin
    case (chr_mode_r)
      bsmm_pkg::CHR_MODE_8K: chr_base = 3'd0;
      bsmm_pkg::CHR_MODE_4K: chr_base = {chr_k[2], 2'b00};
      bsmm_pkg::CHR_MODE_2K: chr_base = {chr_k[2:1], 1'b0};
      default:               chr_base = chr_k;
    endcase
    chr_idx = chr_base;
    if (chr_mode_r[1] && chr_mirror_r && (chr_base[2:1] == 2'b01)) begin
      chr_idx[1] = 1'b0;
    end
  end

  // Result fields known at acceptance.
  logic [7:0]  rd_nxt;
  logic        hit_nxt;
  logic [1:0]  tgt_nxt;
  logic [8:0]  pbank_nxt;
  logic [12:0] off_nxt;
  logic        rw_nxt;
  logic [1:0]  mirror_nxt;
  always_comb begin
    rd_nxt    = 8'd0;
    hit_nxt   = 1'b0;
    tgt_nxt   = bsmm_pkg::TGT_NONE;
    pbank_nxt = 9'd0;
    off_nxt   = 13'd0;
    rw_nxt    = 1'b0;
    if (is_rd) begin
      if (!addr[15]) begin
        case (low_sel)
          bsmm_pkg::REG_ZERO:    hit_nxt = 1'b1;
          bsmm_pkg::REG_MUL_LO:  begin rd_nxt = prod[7:0];  hit_nxt = 1'b1; end
          bsmm_pkg::REG_MUL_HI:  begin rd_nxt = prod[15:8]; hit_nxt = 1'b1; end
          bsmm_pkg::REG_SCRATCH: begin rd_nxt = scratch_r;  hit_nxt = 1'b1; end
          default: begin
            if (ram_win) begin
              tgt_nxt = bsmm_pkg::TGT_PRG_RAM;
              off_nxt = addr[12:0];
            end
          end
        endcase
      end else begin
        tgt_nxt   = bsmm_pkg::TGT_PRG_ROM;
        pbank_nxt = prg_bank;
        off_nxt   = addr[12:0];
      end
    end else if (is_wr) begin
      if (ram_win) begin
        tgt_nxt = bsmm_pkg::TGT_PRG_RAM;
        off_nxt = addr[12:0];
        rw_nxt  = 1'b1;
      end
    end else if (is_ppu) begin
      tgt_nxt = bsmm_pkg::TGT_CHR_ROM;
      off_nxt = {3'b000, addr[9:0]};
    end
    mirror_nxt = wr_mirror ? din[1:0] : mirror_r;
  end

  // Mapper register updates at acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        prg_regs_r[i] <= 7'd0;
      end
      prg_mode_r   <= 3'd0;
      chr_mode_r   <= 2'd0;
      ram_en_r     <= 1'b0;
      chr_mirror_r <= 1'b0;
      blk_en_r     <= 1'b0;
      blk_num_r    <= 3'd0;
      mirror_r     <= 2'd0;
      mul0_r       <= 8'd0;
      mul1_r       <= 8'd0;
      scratch_r    <= 8'd0;
      chr_lo_vld_r <= 8'd0;
      chr_hi_vld_r <= 8'd0;
    end else begin
      if (wr_mul0)    mul0_r    <= din;
      if (wr_mul1)    mul1_r    <= din;
      if (wr_scratch) scratch_r <= din;
      if (wr_prg)     prg_regs_r[addr[1:0]] <= din[6:0];
      if (wr_chr_lo)  chr_lo_vld_r[addr[2:0]] <= 1'b1;
      if (wr_chr_hi)  chr_hi_vld_r[addr[2:0]] <= 1'b1;
      if (wr_mode) begin
        prg_mode_r <= din[2:0];
        chr_mode_r <= din[4:3];
        ram_en_r   <= din[7];
      end
      mirror_r <= mirror_nxt;
      if (wr_chr_ctrl) begin
        chr_mirror_r <= din[7];
        blk_en_r     <= !din[5];
        blk_num_r    <= {din[4:3], din[0]};
      end
    end
  end

  // CHR low and high register memories.
  logic [7:0] chr_lo_rdata;
  logic [7:0] chr_hi_rdata;

  bsmm_ram #(
    .WIDTH (8),
    .DEPTH (8)
  ) u_chr_lo_ram (
    .clk   (clk),
    .we    (wr_chr_lo),
    .waddr (addr[2:0]),
    .wdata (din),
    .re    (accept),
    .raddr (chr_idx),
    .rdata (chr_lo_rdata)
  );

  bsmm_ram #(
    .WIDTH (8),
    .DEPTH (8)
  ) u_chr_hi_ram (
    .clk   (clk),
    .we    (wr_chr_hi),
    .waddr (addr[2:0]),
    .wdata (din),
    .re    (accept),
    .raddr (chr_idx),
    .rdata (chr_hi_rdata)
  );

  // RAM stage: request fields wait here for the CHR read data.
  logic                s1_hit_r;
  logic [7:0]          s1_rd_r;
  logic [1:0]          s1_tgt_r;
  logic [8:0]          s1_pbank_r;
  logic [12:0]         s1_off_r;
  logic                s1_rw_r;
  logic [1:0]          s1_mirror_r;
  bsmm_pkg::chr_ctrl_t s1_chr_r;
  bsmm_pkg::chr_ctrl_t chr_ctrl_nxt;

  always_comb begin
    chr_ctrl_nxt.mode       = chr_mode_r;
    chr_ctrl_nxt.block_en   = blk_en_r;
    chr_ctrl_nxt.block_num  = blk_num_r;
    chr_ctrl_nxt.low_valid  = chr_lo_vld_r[chr_idx];
    chr_ctrl_nxt.high_valid = chr_hi_vld_r[chr_idx];
    chr_ctrl_nxt.k          = chr_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (accept) begin
      s1_rd_r     <= rd_nxt;
      s1_hit_r    <= hit_nxt;
      s1_tgt_r    <= tgt_nxt;
      s1_pbank_r  <= pbank_nxt;
      s1_off_r    <= off_nxt;
      s1_rw_r     <= rw_nxt;
      s1_mirror_r <= mirror_nxt;
      s1_chr_r    <= chr_ctrl_nxt;
    end
  end

  // CHR bank from the register read data.
  logic [BW-1:0] chr_bank;
  logic [BW-1:0] bank_fin;

  bsmm_chr_bank u_chr_bank (
    .ctrl      (s1_chr_r),
    .low_data  (chr_lo_rdata),
    .high_data (chr_hi_rdata),
    .bank      (chr_bank)
  );

  assign bank_fin = (s1_tgt_r == bsmm_pkg::TGT_CHR_ROM) ? chr_bank
                                                       : {10'd0, s1_pbank_r};

  // Output register.
  logic [47:0] out_tdata_r;
  logic [2:0]  out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_tdata_r <= {5'd0, s1_mirror_r, s1_rw_r, s1_off_r, bank_fin, s1_rd_r};
      out_tuser_r <= {s1_tgt_r, s1_hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
